### sv/iq_decimating_fir_macros.svh
// assertion macros used by the checker file
`ifndef IQ_DECIMATING_FIR_MACROS_SVH
`define IQ_DECIMATING_FIR_MACROS_SVH

// same-cycle implication
`define IQDF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iqdf assertion failed");

// next-cycle implication
`define IQDF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iqdf assertion failed");

`endif

### sv/iqdf_pkg.sv
// ----------------------------------------------------------------------------
// iqdf_pkg
// Types and constants of the decimating I/Q FIR filter.
// ----------------------------------------------------------------------------
package iqdf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int OUT_BITS    = 16;
    localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
    localparam int CIDX_W      = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int DEC_W       = 5;
    localparam int TAPS_W      = 8;
    localparam int SHIFT_W     = 5;
    localparam int PHASE_W     = 4;

    localparam int DEC_MAX     = 16;
    localparam int OUT_MAX     = 32767;
    localparam int OUT_MIN     = -32768;

    localparam logic [DEC_W-1:0]   DEC_RESET   = 5'd10;
    localparam logic [TAPS_W-1:0]  TAPS_RESET  = 8'd101;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd15;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECIMATION   = 2'd0,
        CFG_TAP_COUNT    = 2'd1,
        CFG_OUTPUT_SHIFT = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_opcode                       opcode;
        logic signed [SAMPLE_BITS-1:0] sample_i;
        logic signed [SAMPLE_BITS-1:0] sample_q;
        logic [CIDX_W-1:0]             coef_index;
        logic signed [COEF_BITS-1:0]   coef_value;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] out_i;
        logic signed [OUT_BITS-1:0] out_q;
    } t_out_item;

    typedef struct packed {
        logic signed [COEF_BITS-1:0]   coef;
        logic signed [SAMPLE_BITS-1:0] di;
        logic signed [SAMPLE_BITS-1:0] dq;
    } t_tap;

    typedef struct packed {
        logic                        shift;
        logic                        rotate;
        logic                        load;
        logic [CIDX_W-1:0]           coef_index;
        logic signed [COEF_BITS-1:0] coef_value;
    } t_cell_ctl;

    typedef struct packed {
        logic clear;
        logic take;
    } t_mac_ctl;

endpackage

### sv/iqdf_tap_cell.sv
// ----------------------------------------------------------------------------
// iqdf_tap_cell
// One tap of the ring: coefficient and I/Q delay entry, shifts on a sample,
// rotates toward the head during a convolution pass.
// ----------------------------------------------------------------------------
module iqdf_tap_cell
    import iqdf_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_tap      i_left,
    input  t_tap      i_right,
    output t_tap      o_tap
);

    t_tap r_tap;
    t_tap n_tap;
    logic w_hit;

    assign w_hit = i_ctl.load && (IDX < 2 ** CIDX_W) && (i_ctl.coef_index == CIDX_W'(IDX));

    always_comb begin
        n_tap = r_tap;
        if (i_ctl.rotate) begin
            n_tap = i_right;
        end else if (i_ctl.shift) begin
            n_tap.di = i_left.di;
            n_tap.dq = i_left.dq;
        end
        if (w_hit) begin
            n_tap.coef = i_ctl.coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
        end else begin
            r_tap <= n_tap;
        end
    end

    assign o_tap = r_tap;

endmodule

### sv/iqdf_mac.sv
// ----------------------------------------------------------------------------
// iqdf_mac
// Shared I/Q multiply-accumulate at the head of the tap ring, with rounding
// shift and saturation of the sums.
// ----------------------------------------------------------------------------
module iqdf_mac
    import iqdf_pkg::*;
#(
    parameter int ACC_W = 39
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mac_ctl           i_ctl,
    input  t_tap               i_head,
    input  logic [SHIFT_W-1:0] i_shift,
    output t_out_item          o_result
);

    logic signed [PROD_W-1:0] r_prod_i;
    logic signed [PROD_W-1:0] r_prod_q;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc_i;
    logic signed [ACC_W-1:0]  r_acc_q;

    function automatic logic signed [OUT_BITS-1:0] f_finish(
        input logic signed [ACC_W-1:0] acc,
        input logic [SHIFT_W-1:0]      sh
    );
        logic signed [ACC_W:0] rnd;
        logic signed [ACC_W:0] v;
        rnd = '0;
        if (sh != '0) begin
            rnd[sh - 1'b1] = 1'b1;
        end
        v = (ACC_W + 1)'(acc) + rnd;
        v = v >>> sh;
        if (v > (ACC_W + 1)'(OUT_MAX)) begin
            return OUT_BITS'(OUT_MAX);
        end else if (v < (ACC_W + 1)'(OUT_MIN)) begin
            return OUT_BITS'(OUT_MIN);
        end
        return OUT_BITS'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        r_prod_i <= PROD_W'(i_head.coef) * PROD_W'(i_head.di);
        r_prod_q <= PROD_W'(i_head.coef) * PROD_W'(i_head.dq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.take && !i_ctl.clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (i_ctl.clear) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (r_prod_vld) begin
            r_acc_i <= r_acc_i + ACC_W'(r_prod_i);
            r_acc_q <= r_acc_q + ACC_W'(r_prod_q);
        end
    end

    always_comb begin
        o_result.out_i = f_finish(r_acc_i, i_shift);
        o_result.out_q = f_finish(r_acc_q, i_shift);
    end

endmodule

### sv/iq_decimating_fir.sv
// ----------------------------------------------------------------------------
// iq_decimating_fir
// Decimating FIR low-pass filter on paired I/Q samples with shared coefficients.
// Load items and non-output samples are accepted without stalling the input.
// An output sample rotates the tap ring once past one shared I/Q MAC in the RUN,
// FLUSH and DONE states, input stalled until the result is registered.
// Synchronous active-low reset clears taps, coefficients and phase; registers take defaults.
// ----------------------------------------------------------------------------
module iq_decimating_fir
    import iqdf_pkg::*;
#(
    parameter int MAX_TAPS = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
    localparam int STEP_W = $clog2(MAX_TAPS + 1);

    t_state               r_state;
    t_state               n_state;
    logic [STEP_W-1:0]    r_step;
    logic [STEP_W-1:0]    n_step;
    logic [PHASE_W-1:0]   r_phase;
    logic [PHASE_W-1:0]   n_phase;
    logic [DEC_W-1:0]     r_decimation;
    logic [TAPS_W-1:0]    r_tap_count;
    logic [SHIFT_W-1:0]   r_output_shift;
    logic                 r_out_vld;
    t_out_item            r_out_item;

    logic                 w_in_acc;
    logic                 w_out_load;
    logic [DEC_W-1:0]     w_dec;
    logic [DEC_W-1:0]     w_phase_inc;
    logic [STEP_W-1:0]    w_taps;
    t_cell_ctl            w_cell_ctl;
    t_mac_ctl             w_mac_ctl;
    t_tap                 w_new;
    t_tap                 w_tap   [MAX_TAPS];
    t_tap                 w_left  [MAX_TAPS];
    t_tap                 w_right [MAX_TAPS];
    t_out_item            w_result;

    assign o_stall  = (r_state != ST_IDLE);
    assign w_in_acc = i_valid && !o_stall;

    assign w_dec = (r_decimation == '0) ? DEC_W'(1) :
                   (r_decimation > DEC_W'(DEC_MAX)) ? DEC_W'(DEC_MAX) : r_decimation;
    assign w_phase_inc = DEC_W'(r_phase) + DEC_W'(1);
    assign w_taps = (32'(r_tap_count) > MAX_TAPS) ? STEP_W'(MAX_TAPS) : STEP_W'(r_tap_count);

    always_comb begin
        w_new      = '0;
        w_new.di   = i_item.sample_i;
        w_new.dq   = i_item.sample_q;
    end

    // tap ring
    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_left[k] = w_new;
        end else begin : g_body
            assign w_left[k] = w_tap[k-1];
        end
        assign w_right[k] = w_tap[(k + 1) % MAX_TAPS];

        iqdf_tap_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_cell_ctl),
            .i_left  (w_left[k]),
            .i_right (w_right[k]),
            .o_tap   (w_tap[k])
        );
    end

    iqdf_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_head   (w_tap[0]),
        .i_shift  (r_output_shift),
        .o_result (w_result)
    );

    always_comb begin
        n_state               = r_state;
        n_step                = r_step;
        n_phase               = r_phase;
        w_cell_ctl            = '0;
        w_cell_ctl.coef_index = i_item.coef_index;
        w_cell_ctl.coef_value = i_item.coef_value;
        w_mac_ctl             = '0;
        w_out_load            = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_item.opcode == OP_LOAD) begin
                        w_cell_ctl.load = 1'b1;
                    end else begin
                        w_cell_ctl.shift = 1'b1;
                        n_phase = (w_phase_inc >= w_dec) ? '0 : w_phase_inc[PHASE_W-1:0];
                        if (r_phase == '0) begin
                            n_state         = ST_RUN;
                            n_step          = '0;
                            w_mac_ctl.clear = 1'b1;
                        end
                    end
                end
            end
            ST_RUN: begin
                w_cell_ctl.rotate = 1'b1;
                w_mac_ctl.take    = (r_step < w_taps);
                if (r_step == STEP_W'(MAX_TAPS - 1)) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_FLUSH: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_vld || !i_stall) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_phase <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decimation   <= DEC_RESET;
            r_tap_count    <= TAPS_RESET;
            r_output_shift <= SHIFT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_DECIMATION:   r_decimation   <= i_cfg_data[DEC_W-1:0];
                CFG_TAP_COUNT:    r_tap_count    <= i_cfg_data[TAPS_W-1:0];
                CFG_OUTPUT_SHIFT: r_output_shift <= i_cfg_data[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_item <= w_result;
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_out_item;

endmodule

### sv/iqdf_checker.sv
// ----------------------------------------------------------------------------
// iqdf_checker
// Port-level checks of the decimating I/Q FIR, bound to the top level.
// ----------------------------------------------------------------------------
`include "iq_decimating_fir_macros.svh"

module iqdf_checker
    import iqdf_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input t_in_item              i_item,
    input logic                  o_valid,
    input logic                  i_stall,
    input t_out_item             o_item,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic w_in_acc;
    logic w_cfg_seen;

    assign w_in_acc   = i_valid && !o_stall;
    assign w_cfg_seen = i_cfg_we && (i_cfg_index == i_cfg_index) && (i_cfg_data == i_cfg_data);

    // a result only comes out of a convolution pass, which holds the input side
    `IQDF_ASSERT_IMP(a_result_after_pass, i_clk, i_rst_n, $rose(o_valid), $past(o_stall))
    // an accepted item never yields a result in the very next cycle
    `IQDF_ASSERT_NXT(a_no_instant_result, i_clk, i_rst_n, w_in_acc && !o_valid, !o_valid)
    // a coefficient load never starts a pass
    `IQDF_ASSERT_NXT(a_load_no_stall, i_clk, i_rst_n,
        w_in_acc && (i_item.opcode == OP_LOAD), !o_stall)
    // a stalled result holds
    `IQDF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_item))
    // register writes leave the handshake alone
    `IQDF_ASSERT_NXT(a_cfg_idle, i_clk, i_rst_n, w_cfg_seen && !o_stall && !o_valid && !i_valid,
        !o_valid)

endmodule

bind iq_decimating_fir iqdf_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_item      (i_item),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_item      (o_item),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

### tb/tb_iq_decimating_fir.sv
// ----------------------------------------------------------------------------
// tb_iq_decimating_fir
// Self-checking testbench of the decimating I/Q FIR filter. Directed items
// cover the field extremes, the register corners, rounding and saturation.
// Random streams of coefficient loads and samples then run under several
// register settings. Every result is checked against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_iq_decimating_fir;
    import iqdf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS_MAX = 128;
    localparam int SETTLE   = TAPS_MAX + 16;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    t_in_item              i_item      = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    t_out_item             o_item;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    iq_decimating_fir #(
        .MAX_TAPS(TAPS_MAX)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    logic signed [COEF_BITS-1:0]   coef_mem [TAPS_MAX];
    logic signed [SAMPLE_BITS-1:0] hist_i   [TAPS_MAX];
    logic signed [SAMPLE_BITS-1:0] hist_q   [TAPS_MAX];
    int                            phase_cnt;
    logic [DEC_W-1:0]              reg_dec;
    logic [TAPS_W-1:0]             reg_taps;
    logic [SHIFT_W-1:0]            reg_shift;

    t_out_item pending_out[$];
    int        fail_count   = 0;
    int        items_sent   = 0;
    bit        quiet        = 1'b0;
    int        rx_hold      = 0;
    bit        rx_busy      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic signed [OUT_BITS-1:0] scale_sat(longint acc);
        longint v;
        v = acc;
        if (reg_shift != 0) v = v + (longint'(1) <<< (reg_shift - 1));
        v = v >>> reg_shift;
        if (v > OUT_MAX) v = OUT_MAX;
        else if (v < OUT_MIN) v = OUT_MIN;
        return v[OUT_BITS-1:0];
    endfunction

    task automatic filter_predict(t_in_item it);
        int        dec_eff;
        int        ntaps;
        longint    acc_i;
        longint    acc_q;
        t_out_item res;
        if (it.opcode == OP_LOAD) begin
            coef_mem[it.coef_index] = it.coef_value;
        end else begin
            for (int k = TAPS_MAX - 1; k > 0; k--) begin
                hist_i[k] = hist_i[k-1];
                hist_q[k] = hist_q[k-1];
            end
            hist_i[0] = it.sample_i;
            hist_q[0] = it.sample_q;
            dec_eff = (reg_dec == 0) ? 1 : (reg_dec > DEC_MAX) ? DEC_MAX : int'(reg_dec);
            if (phase_cnt == 0) begin
                ntaps = (reg_taps > TAPS_MAX) ? TAPS_MAX : int'(reg_taps);
                acc_i = 0;
                acc_q = 0;
                for (int k = 0; k < ntaps; k++) begin
                    acc_i += longint'(coef_mem[k]) * longint'(hist_i[k]);
                    acc_q += longint'(coef_mem[k]) * longint'(hist_q[k]);
                end
                res.out_i = scale_sat(acc_i);
                res.out_q = scale_sat(acc_q);
                pending_out.push_back(res);
            end
            phase_cnt = (phase_cnt + 1 >= dec_eff) ? 0 : ((phase_cnt + 1) & 15);
        end
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            default: return 16'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    function automatic t_in_item sample_item(logic [15:0] si, logic [15:0] sq);
        t_in_item it;
        it.opcode     = OP_SAMPLE;
        it.sample_i   = si;
        it.sample_q   = sq;
        it.coef_index = CIDX_W'($urandom_range(0, TAPS_MAX - 1));
        it.coef_value = 16'($urandom_range(0, 16'hffff));
        return it;
    endfunction

    function automatic t_in_item coef_item(logic [CIDX_W-1:0] idx, logic [15:0] val);
        t_in_item it;
        it.opcode     = OP_LOAD;
        it.sample_i   = 16'($urandom_range(0, 16'hffff));
        it.sample_q   = 16'($urandom_range(0, 16'hffff));
        it.coef_index = idx;
        it.coef_value = val;
        return it;
    endfunction

    function automatic t_in_item random_item();
        int lim;
        lim = (reg_taps == 0) ? 1 : (reg_taps > TAPS_MAX) ? TAPS_MAX : int'(reg_taps);
        if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1))
                return coef_item(CIDX_W'($urandom_range(0, lim - 1)), rand_word());
            return coef_item(CIDX_W'($urandom_range(0, TAPS_MAX - 1)), rand_word());
        end
        return sample_item(rand_word(), rand_word());
    endfunction

    task automatic push_item(t_in_item it);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        filter_predict(it);
        items_sent++;
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apply_settings(logic [7:0] dec, logic [7:0] taps, logic [7:0] shift);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DECIMATION;
        i_cfg_data  <= dec;
        @(posedge i_clk);
        i_cfg_index <= CFG_TAP_COUNT;
        i_cfg_data  <= taps;
        @(posedge i_clk);
        i_cfg_index <= CFG_OUTPUT_SHIFT;
        i_cfg_data  <= shift;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        reg_dec   = dec[DEC_W-1:0];
        reg_taps  = taps[TAPS_W-1:0];
        reg_shift = shift[SHIFT_W-1:0];
    endtask

    // reset values, all coefficients zero
    task automatic test_defaults();
        push_item(sample_item(16'h7fff, 16'h8000));
        push_item(sample_item(16'h8000, 16'h7fff));
    endtask

    task automatic test_coef_extremes();
        settle();
        apply_settings(8'd1, 8'd128, 8'd0);
        push_item(coef_item(7'd0, 16'h8000));
        push_item(coef_item(7'd127, 16'h7fff));
        push_item(coef_item(7'd1, 16'h7fff));
        push_item(sample_item(16'h8000, 16'h7fff));
        push_item(sample_item(16'h7fff, 16'h8000));
        push_item(sample_item(16'h0000, 16'hffff));
    endtask

    task automatic test_register_corners();
        settle();
        apply_settings(8'd0, 8'd0, 8'd31);
        push_item(sample_item(16'h1234, 16'hedcb));
        push_item(sample_item(16'h7fff, 16'h8000));
        settle();
        apply_settings(8'd31, 8'd255, 8'd31);
        push_item(sample_item(16'h8000, 16'h8000));
        // lower decimation while the phase sits above it
        settle();
        apply_settings(8'd16, 8'd128, 8'd15);
        repeat (5) push_item(sample_item(rand_word(), rand_word()));
        settle();
        apply_settings(8'd2, 8'd128, 8'd15);
        repeat (3) push_item(sample_item(rand_word(), rand_word()));
    endtask

    task automatic test_rounding();
        settle();
        apply_settings(8'd1, 8'd1, 8'd1);
        push_item(coef_item(7'd0, 16'h0001));
        push_item(sample_item(16'h0001, 16'hffff));
        push_item(sample_item(16'h0003, 16'hfffd));
    endtask

    task automatic test_random_streams();
        logic [7:0] dec;
        logic [7:0] taps;
        logic [7:0] shift;
        while (items_sent < 370) begin
            settle();
            case ($urandom_range(0, 7))
                0:       dec = 8'd1;
                1:       dec = 8'd16;
                2:       dec = 8'd0;
                3:       dec = 8'($urandom_range(17, 31));
                default: dec = 8'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 7))
                0:       taps = 8'd0;
                1:       taps = 8'd1;
                2:       taps = 8'd128;
                3:       taps = 8'($urandom_range(129, 255));
                default: taps = 8'($urandom_range(1, 128));
            endcase
            case ($urandom_range(0, 5))
                0:       shift = 8'd0;
                1:       shift = 8'd31;
                2:       shift = 8'($urandom_range(0, 31));
                default: shift = 8'($urandom_range(10, 20));
            endcase
            apply_settings(dec, taps, shift);
            repeat ($urandom_range(50, 90)) push_item(random_item());
        end
    endtask

    task automatic test_quiet_tail();
        settle();
        quiet = 1'b1;
        apply_settings(8'd1, 8'($urandom_range(1, 128)), 8'd15);
        repeat (40) push_item(random_item());
    endtask

    always @(posedge i_clk) begin
        if (quiet) begin
            i_stall <= 1'b0;
        end else begin
            if (rx_hold == 0) begin
                rx_busy = ($urandom_range(0, 2) == 0);
                rx_hold = rx_busy ? $urandom_range(1, 9) : $urandom_range(1, 40);
            end
            rx_hold--;
            i_stall <= rx_busy;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_out.size() == 0) begin
                $error("unexpected item: out_i %0d out_q %0d", o_item.out_i, o_item.out_q);
                fail_count++;
            end else begin
                want = pending_out.pop_front();
                if (o_item.out_i !== want.out_i) begin
                    $error("out_i mismatch: expected %0d, got %0d", want.out_i, o_item.out_i);
                    fail_count++;
                end
                if (o_item.out_q !== want.out_q) begin
                    $error("out_q mismatch: expected %0d, got %0d", want.out_q, o_item.out_q);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        for (int k = 0; k < TAPS_MAX; k++) begin
            coef_mem[k] = '0;
            hist_i[k]   = '0;
            hist_q[k]   = '0;
        end
        phase_cnt = 0;
        reg_dec   = DEC_RESET;
        reg_taps  = TAPS_RESET;
        reg_shift = SHIFT_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_coef_extremes();
        test_register_corners();
        test_rounding();
        test_random_streams();
        test_quiet_tail();
        settle();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/iqdf_pkg.sv
sv/iqdf_tap_cell.sv
sv/iqdf_mac.sv
sv/iq_decimating_fir.sv
sv/iqdf_checker.sv
tb/tb_iq_decimating_fir.sv
